// ===== design/shta_pkg.sv =====
// Package for the signed hundredths to ASCII converter.
// Holds widths, character codes, the divide-by-ten constants and the
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package shta_pkg;

    localparam int VALUE_BITS  = 24;
    localparam int MAG_BITS    = 24;
    localparam int NUM_DIGITS  = 7;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int MAX_CHARS   = 9;
    localparam int CHAR_CNT_W  = $clog2(MAX_CHARS + 1);
    localparam int WHOLE_W     = $clog2(NUM_DIGITS - 1);

    localparam logic [31:0] MAG_LIMIT = 32'd9999999;

    // v / 10 == (v * RECIP) >> RECIP_SHIFT, exact for any 32-bit v
    localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_BITS   = MAG_BITS + 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [7:0]                   t_char;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic last;
    } t_status;

endpackage

// ===== design/shta_if.sv =====
// Stream interfaces for the signed hundredths to ASCII converter:
// value input channel and character output channel. Depends on shta_pkg.
`timescale 1ns / 1ps

interface shta_in_if;
    logic            valid;
    logic            ready;
    shta_pkg::t_value value_hundredths;

    modport source (output valid, output value_hundredths, input ready);
    modport sink   (input valid, input value_hundredths, output ready);
endinterface

interface shta_out_if;
    logic            valid;
    logic            ready;
    shta_pkg::t_char ascii_char;
    logic            last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// ===== design/shta_ctrl.sv =====
// Controller for the signed hundredths to ASCII converter: sequences
// load, digit conversion and character emission. Depends on shta_pkg.
`timescale 1ns / 1ps

module shta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output shta_pkg::t_cmd    o_cmd,
    input  shta_pkg::t_status i_status
);
    import shta_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.advance = 1'b1;
                    // drop back to idle after the final character
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/shta_datapath.sv =====
// Datapath for the signed hundredths to ASCII converter: magnitude and
// clamp, one divide-by-ten per cycle, digit store and character select.
// Depends on shta_pkg.
`timescale 1ns / 1ps

module shta_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shta_pkg::t_value  i_value,
    input  shta_pkg::t_cmd    i_cmd,
    output shta_pkg::t_status o_status,
    output shta_pkg::t_char   o_char
);
    import shta_pkg::*;

    logic [MAG_BITS-1:0]    r_val;
    logic                   r_neg;
    logic [3:0]             r_dig [NUM_DIGITS];
    logic [DIGIT_IDX_W-1:0] r_k;
    logic [WHOLE_W-1:0]     r_nwhole;
    logic [CHAR_CNT_W-1:0]  r_e;

    // magnitude, held to the field range and to the text length
    logic                  neg;
    logic [VALUE_BITS-1:0] mag_v;
    logic [31:0]           mag_ext;
    logic [MAG_BITS-1:0]   mag;

    always_comb begin
        neg   = i_value[VALUE_BITS-1];
        mag_v = neg ? (~i_value + VALUE_BITS'(1)) : i_value;
        if (neg && mag_v[VALUE_BITS-1]) begin
            mag_v = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
        mag_ext = 32'(mag_v);
        if (mag_ext > MAG_LIMIT) begin
            mag_ext = MAG_LIMIT;
        end
        mag = mag_ext[MAG_BITS-1:0];
    end

    // divide by ten through the reciprocal
    logic [PROD_BITS-1:0] prod;
    logic [MAG_BITS-1:0]  quot;
    logic [MAG_BITS-1:0]  rem_full;

    assign prod     = PROD_BITS'(r_val) * PROD_BITS'(RECIP);
    assign quot     = MAG_BITS'(prod >> RECIP_SHIFT);
    assign rem_full = r_val - MAG_BITS'(quot * MAG_BITS'(10));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_e <= '0;
        end else begin
            if (i_cmd.load) begin
                r_val    <= mag;
                r_neg    <= neg;
                r_k      <= '0;
                r_nwhole <= '0;
                r_e      <= '0;
            end
            if (i_cmd.step) begin
                r_dig[r_k] <= rem_full[3:0];
                r_val      <= quot;
                r_k        <= r_k + DIGIT_IDX_W'(1);
                // a nonzero quotient at this place means a whole digit here
                if (r_k >= DIGIT_IDX_W'(2) && r_val != '0) begin
                    r_nwhole <= WHOLE_W'(r_k - DIGIT_IDX_W'(1));
                end
            end
            if (i_cmd.advance) begin
                r_e <= r_e + CHAR_CNT_W'(1);
            end
        end
    end

    // character select for emission slot r_e
    logic [CHAR_CNT_W-1:0]  count;
    logic [CHAR_CNT_W-1:0]  j;
    logic [CHAR_CNT_W-1:0]  nw;
    logic [DIGIT_IDX_W-1:0] d_idx;

    always_comb begin
        nw    = CHAR_CNT_W'(r_nwhole);
        count = CHAR_CNT_W'(r_neg) + nw + CHAR_CNT_W'(3);
        j     = r_e - CHAR_CNT_W'(r_neg);
        if (j < nw) begin
            d_idx = DIGIT_IDX_W'(nw + CHAR_CNT_W'(1) - j);
        end else begin
            d_idx = DIGIT_IDX_W'(nw + CHAR_CNT_W'(2) - j);
        end
        priority if (r_neg && r_e == '0) begin
            o_char = CHAR_MINUS;
        end else if (j == nw) begin
            o_char = CHAR_DOT;
        end else begin
            o_char = CHAR_ZERO + {4'b0, r_dig[d_idx]};
        end
    end

    assign o_status.conv_done = (r_k == DIGIT_IDX_W'(NUM_DIGITS - 1));
    assign o_status.last      = (r_e == count - CHAR_CNT_W'(1));

endmodule

// ===== design/signed_hundredths_to_ascii_core.sv =====
// Signed hundredths to ASCII converter, top level.
// Sequence: accept, then digit extraction by repeated divide-by-ten, then
// one character per cycle (3 to 9 characters) while the sink is ready.
// A new value is accepted only after the last character of the one before has been sent;
// the single shared divide-by-ten step and the one-character output port set the pace.
// Reset: synchronous active low; returns to idle, discarding any value.
`timescale 1ns / 1ps

module signed_hundredths_to_ascii_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    shta_in_if.sink    i_in,
    shta_out_if.source o_out
);
    import shta_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;
    t_char   ch;

    shta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    shta_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_in.value_hundredths),
        .i_cmd    (cmd),
        .o_status (status),
        .o_char   (ch)
    );

    assign i_in.ready       = in_ready;
    assign o_out.valid      = out_valid;
    assign o_out.ascii_char = ch;
    assign o_out.last_char  = status.last;

endmodule
